### rtl/tbdk_pkg.sv
// ----------------------------------------------------------------------------
// tbdk_pkg
// Shared types, register map and event table of the two-button key mapper.
// ----------------------------------------------------------------------------
package tbdk_pkg;

  localparam int unsigned NUM_EV = 10;
  localparam int unsigned EV_IDX_W = 4;

  typedef logic [NUM_EV-1:0]   ev_mask_t;
  typedef logic [EV_IDX_W-1:0] ev_idx_t;

  localparam ev_idx_t EV_UP_DN   = 4'd0;
  localparam ev_idx_t EV_UP_UP   = 4'd1;
  localparam ev_idx_t EV_ESC_DN  = 4'd2;
  localparam ev_idx_t EV_ESC_UP  = 4'd3;
  localparam ev_idx_t EV_SPC_DN  = 4'd4;
  localparam ev_idx_t EV_SPC_UP  = 4'd5;
  localparam ev_idx_t EV_ENT_DN  = 4'd6;
  localparam ev_idx_t EV_ENT_UP  = 4'd7;
  localparam ev_idx_t EV_RCTL_DN = 4'd8;
  localparam ev_idx_t EV_RCTL_UP = 4'd9;

  localparam logic [2:0] KEY_UP     = 3'd0;
  localparam logic [2:0] KEY_ESC    = 3'd1;
  localparam logic [2:0] KEY_RETURN = 3'd2;
  localparam logic [2:0] KEY_RCTL   = 3'd3;
  localparam logic [2:0] KEY_SPACE  = 3'd4;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONGPRESS = 2'd1;
  localparam logic [1:0] REG_A_ENABLE = 2'd2;
  localparam logic [1:0] REG_B_ENABLE = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST = 16'd30;
  localparam logic [15:0] LONGPRESS_RST = 16'd600;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] longpress_ms;
    logic        a_enable;
    logic        b_enable;
  } cfg_t;

  function automatic logic [2:0] ev_code(ev_idx_t idx);
    logic [2:0] code;
    unique case (idx)
      EV_UP_DN, EV_UP_UP:     code = KEY_UP;
      EV_ESC_DN, EV_ESC_UP:   code = KEY_ESC;
      EV_SPC_DN, EV_SPC_UP:   code = KEY_SPACE;
      EV_ENT_DN, EV_ENT_UP:   code = KEY_RETURN;
      EV_RCTL_DN, EV_RCTL_UP: code = KEY_RCTL;
      default:                code = KEY_UP;
    endcase
    return code;
  endfunction

  function automatic logic ev_down(ev_idx_t idx);
    return ~idx[0];
  endfunction

endpackage

### rtl/two_button_debounce_longpress_keys.sv
// ----------------------------------------------------------------------------
// two_button_debounce_longpress_keys
// Two-button debouncer with long-press detection, mapped onto key events.
// ----------------------------------------------------------------------------
// A tick (timestamp plus the raw levels of buttons A and B) is accepted in any
// cycle in which the event queue has room; the classifier settles both
// buttons and the press timers for that tick in the cycle it is accepted.
// Each tick yields zero to seven key events, which the emitter drains one per
// cycle while pop keeps the output stage free; a tick without events never
// enters the queue. Up to QUEUE_DEPTH ticks with pending events buffer between
// the two sides. The last event of a tick carries last_event_o. Registers on
// the APB port: debounce time (0x0), long-press time (0x4), button A enable
// (0x8), button B enable (0xC).
// ----------------------------------------------------------------------------
module two_button_debounce_longpress_keys #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [31:0] now_ms_i,
  input  logic        level_a_i,
  input  logic        level_b_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  key_code_o,
  output logic        key_down_o,
  output logic        last_event_o
);
  import tbdk_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr, accept, mask_push, q_full, q_empty, q_pop;
  logic [1:0] reg_idx;
  ev_mask_t   mask, q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= DEBOUNCE_RST;
      cfg_q.longpress_ms <= LONGPRESS_RST;
      cfg_q.a_enable     <= 1'b1;
      cfg_q.b_enable     <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEBOUNCE:  cfg_q.debounce_ms  <= pwdata[15:0];
        REG_LONGPRESS: cfg_q.longpress_ms <= pwdata[15:0];
        REG_A_ENABLE:  cfg_q.a_enable     <= pwdata[0];
        REG_B_ENABLE:  cfg_q.b_enable     <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:  prdata = {16'd0, cfg_q.debounce_ms};
      REG_LONGPRESS: prdata = {16'd0, cfg_q.longpress_ms};
      REG_A_ENABLE:  prdata = {31'd0, cfg_q.a_enable};
      REG_B_ENABLE:  prdata = {31'd0, cfg_q.b_enable};
    endcase
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  tbdk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .now_ms_i    (now_ms_i),
    .level_a_i   (level_a_i),
    .level_b_i   (level_b_i),
    .mask_push_o (mask_push),
    .mask_o      (mask)
  );

  tbdk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mask_push),
    .data_i  (mask),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tbdk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (q_data),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .key_code_o   (key_code_o),
    .key_down_o   (key_down_o),
    .last_event_o (last_event_o)
  );

endmodule

### rtl/tbdk_front.sv
// ----------------------------------------------------------------------------
// tbdk_front
// Debounce both buttons, track press timing and classify each tick into a
// mask of the key events it causes.
// ----------------------------------------------------------------------------
module tbdk_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbdk_pkg::cfg_t    cfg_i,
  input  logic              accept_i,
  input  logic [31:0]       now_ms_i,
  input  logic              level_a_i,
  input  logic              level_b_i,
  output logic              mask_push_o,
  output tbdk_pkg::ev_mask_t mask_o
);
  import tbdk_pkg::*;

  logic        raw_a_q, raw_a_d, stable_a_q, stable_a_d, long_a_q, long_a_d;
  logic [31:0] chg_a_q, chg_a_d, press_a_q, press_a_d;
  logic        raw_b_q, raw_b_d, stable_b_q, stable_b_d, long_b_q, long_b_d;
  logic        arrow_b_q, arrow_b_d;
  logic [31:0] chg_b_q, chg_b_d, press_b_q, press_b_d;

  logic        flip_a, flip_b, a_press, b_press, a_long, b_long, a_rel, b_rel_up;
  logic        long_a_pre, long_b_pre, arrow_b_pre, ovf;
  logic [31:0] deb_diff_a, deb_diff_b, lp_diff_a, lp_diff_b, deb_ms, lp_ms;
  ev_mask_t    mask;

  always_comb begin
    deb_ms = {16'd0, cfg_i.debounce_ms};
    lp_ms  = {16'd0, cfg_i.longpress_ms};

    flip_a     = cfg_i.a_enable && (level_a_i != raw_a_q);
    raw_a_d    = cfg_i.a_enable ? level_a_i : raw_a_q;
    chg_a_d    = flip_a ? now_ms_i : chg_a_q;
    deb_diff_a = flip_a ? 32'd0 : (now_ms_i - chg_a_q);
    stable_a_d = (cfg_i.a_enable && (stable_a_q != raw_a_d) && (deb_diff_a >= deb_ms))
                 ? raw_a_d : stable_a_q;

    flip_b     = cfg_i.b_enable && (level_b_i != raw_b_q);
    raw_b_d    = cfg_i.b_enable ? level_b_i : raw_b_q;
    chg_b_d    = flip_b ? now_ms_i : chg_b_q;
    deb_diff_b = flip_b ? 32'd0 : (now_ms_i - chg_b_q);
    stable_b_d = (cfg_i.b_enable && (stable_b_q != raw_b_d) && (deb_diff_b >= deb_ms))
                 ? raw_b_d : stable_b_q;

    b_press     = stable_b_d && !stable_b_q;
    press_b_d   = b_press ? now_ms_i : press_b_q;
    long_b_pre  = b_press ? 1'b0 : long_b_q;
    arrow_b_pre = b_press ? 1'b1 : arrow_b_q;
    lp_diff_b   = b_press ? 32'd0 : (now_ms_i - press_b_q);
    b_long      = stable_b_d && arrow_b_pre && !long_b_pre && (lp_diff_b >= lp_ms);
    b_rel_up    = !stable_b_d && stable_b_q && arrow_b_pre;
    long_b_d    = long_b_pre || b_long;
    arrow_b_d   = arrow_b_pre && !b_long && !(!stable_b_d && stable_b_q);

    a_press    = stable_a_d && !stable_a_q;
    press_a_d  = a_press ? now_ms_i : press_a_q;
    long_a_pre = a_press ? 1'b0 : long_a_q;
    lp_diff_a  = a_press ? 32'd0 : (now_ms_i - press_a_q);
    a_long     = stable_a_d && !long_a_pre && (lp_diff_a >= lp_ms);
    a_rel      = !stable_a_d && stable_a_q && !long_a_pre;
    long_a_d   = long_a_pre || a_long;

    // drop the up-arrow pair when a tick would carry eight events
    ovf = b_press && b_long && a_rel;

    mask             = '0;
    mask[EV_UP_DN]   = b_press && !ovf;
    mask[EV_UP_UP]   = (b_long && !ovf) || b_rel_up;
    mask[EV_ESC_DN]  = b_long;
    mask[EV_ESC_UP]  = b_long;
    mask[EV_SPC_DN]  = a_long;
    mask[EV_SPC_UP]  = a_long;
    mask[EV_ENT_DN]  = a_rel;
    mask[EV_ENT_UP]  = a_rel;
    mask[EV_RCTL_DN] = a_rel;
    mask[EV_RCTL_UP] = a_rel;
  end

  assign mask_o      = mask;
  assign mask_push_o = accept_i && (mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_a_q    <= 1'b0;
      stable_a_q <= 1'b0;
      long_a_q   <= 1'b0;
      chg_a_q    <= '0;
      press_a_q  <= '0;
      raw_b_q    <= 1'b0;
      stable_b_q <= 1'b0;
      long_b_q   <= 1'b0;
      arrow_b_q  <= 1'b0;
      chg_b_q    <= '0;
      press_b_q  <= '0;
    end else if (accept_i) begin
      raw_a_q    <= raw_a_d;
      stable_a_q <= stable_a_d;
      long_a_q   <= long_a_d;
      chg_a_q    <= chg_a_d;
      press_a_q  <= press_a_d;
      raw_b_q    <= raw_b_d;
      stable_b_q <= stable_b_d;
      long_b_q   <= long_b_d;
      arrow_b_q  <= arrow_b_d;
      chg_b_q    <= chg_b_d;
      press_b_q  <= press_b_d;
    end
  end

`ifndef SYNTHESIS
  a_arrow_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arrow_b_q |-> stable_b_q && !long_b_q)
    else $error("arrow held without a live press of button B");
  a_esc_ordering: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_push_o && mask_o[EV_ESC_DN] |-> mask_o[EV_UP_UP] || mask_o[EV_ENT_DN])
    else $error("escape pair without up-arrow release or overflow");
  a_a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_push_o |-> !(mask_o[EV_SPC_DN] && mask_o[EV_ENT_DN]))
    else $error("button A long press and short release in one tick");
`endif

endmodule

### rtl/tbdk_queue.sv
// ----------------------------------------------------------------------------
// tbdk_queue
// Small queue of event masks between the classifier and the event emitter.
// ----------------------------------------------------------------------------
module tbdk_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tbdk_pkg::ev_mask_t data_i,
  input  logic               pop_i,
  output tbdk_pkg::ev_mask_t data_o,
  output logic               full_o,
  output logic               empty_o
);
  import tbdk_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  ev_mask_t        mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### rtl/tbdk_back.sv
// ----------------------------------------------------------------------------
// tbdk_back
// Expand each event mask into key events, lowest bit first, into a registered
// output stage, one per cycle while that stage is empty or being popped.
// ----------------------------------------------------------------------------
module tbdk_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbdk_pkg::ev_mask_t q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [2:0]         key_code_o,
  output logic               key_down_o,
  output logic               last_event_o
);
  import tbdk_pkg::*;

  ev_mask_t   cur_q, cur_d, rest;
  ev_idx_t    sel;
  logic       out_valid_q, out_valid_d, out_free, emit, load;
  logic [2:0] code_q;
  logic       down_q, last_q;

  always_comb begin
    sel = '0;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (cur_q[i]) begin
        sel = ev_idx_t'(i);
      end
    end
    rest      = cur_q;
    rest[sel] = 1'b0;

    out_free = !out_valid_q || pop_i;
    emit     = out_free && (cur_q != '0);
    load     = !q_empty_i && ((cur_q == '0) || (emit && (rest == '0)));

    cur_d = emit ? rest : cur_q;
    if (load) begin
      cur_d = q_data_i;
    end
    out_valid_d = emit || (out_valid_q && !pop_i);
  end

  assign q_pop_o      = load;
  assign empty_o      = !out_valid_q;
  assign key_code_o   = code_q;
  assign key_down_o   = down_q;
  assign last_event_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      code_q <= ev_code(sel);
      down_q <= ev_down(sel);
      last_q <= (rest == '0);
    end
  end

`ifndef SYNTHESIS
  a_load_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_data_i != '0)
    else $error("empty event mask taken from the queue");
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> key_code_o <= KEY_SPACE)
    else $error("key code out of range");
`endif

endmodule
